// ----- rtl/br2m_pkg.sv -----
// shared constants and stage data type for the radix-2 booth multiplier
package br2m_pkg;

    // operand width, 2 to 32
    localparam int WIDTH = 32;
    // port widths of the operand and product fields
    localparam int FIELD_W = 32;
    localparam int PROD_W = 64;
    // accumulator carries one extra bit for the most negative operands
    localparam int ACC_W = WIDTH + 1;

    // booth pair {current multiplier bit, previous bit}
    localparam logic [1:0] BOOTH_ADD = 2'b01;
    localparam logic [1:0] BOOTH_SUB = 2'b10;

    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        logic [WIDTH-1:0]        q;
        logic                    qprev;
        logic signed [WIDTH-1:0] m;
    } br2m_data_t;

endpackage

// ----- rtl/br2m_stage.sv -----
// one booth step followed by a pipeline register with valid and back-pressure
module br2m_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  br2m_pkg::br2m_data_t in_data,
    output logic                 in_ready,
    output logic                 out_valid,
    output br2m_pkg::br2m_data_t out_data,
    input  logic                 out_ready
);

    logic                    valid_reg;
    br2m_pkg::br2m_data_t    data_reg;
    br2m_pkg::br2m_data_t    data_next;
    logic signed [br2m_pkg::ACC_W-1:0] m_ext;
    logic signed [br2m_pkg::ACC_W-1:0] sum;

    // add, subtract or keep the accumulator, then shift the pair right
    always_comb
    begin
        m_ext = br2m_pkg::ACC_W'(in_data.m);
        case ({in_data.q[0], in_data.qprev})
            br2m_pkg::BOOTH_ADD: sum = in_data.acc + m_ext;
            br2m_pkg::BOOTH_SUB: sum = in_data.acc - m_ext;
            default:             sum = in_data.acc;
        endcase
        data_next.acc   = sum >>> 1;
        data_next.q     = {sum[0], in_data.q[br2m_pkg::WIDTH-1:1]};
        data_next.qprev = in_data.q[0];
        data_next.m     = in_data.m;
    end

    // register may load when empty or when its contents move on
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/booth_radix2_signed_multiplier_top.sv -----
// top level of the pipelined radix-2 booth signed multiplier
// pipeline: WIDTH stage registers, one booth step in front of each
// throughput: one transaction per cycle while the output is not stalled, set by one booth step per pipeline stage
// bubbles collapse: an empty stage takes new data even while the output is stalled
// reset: rst_n asynchronously clears every stage valid bit; data registers are not reset
// output product comes straight off the last stage register
module booth_radix2_signed_multiplier_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [br2m_pkg::FIELD_W-1:0] multiplier_in,
    input  logic signed [br2m_pkg::FIELD_W-1:0] multiplicand_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [br2m_pkg::PROD_W-1:0]  product_out
);

    // stage k sees the output of stage k-1; index 0 is the input port
    logic                 stage_valid [0:br2m_pkg::WIDTH];
    logic                 stage_ready [0:br2m_pkg::WIDTH];
    br2m_pkg::br2m_data_t stage_data  [0:br2m_pkg::WIDTH];

    // full product: extra accumulator bit on top of the shifted-out multiplier bits
    logic signed [2*br2m_pkg::WIDTH:0] prod;

    // initial booth state: empty accumulator, multiplier in q, previous bit zero
    // narrow widths only use the low operand bits
    always_comb
    begin
        stage_data[0].acc   = '0;
        stage_data[0].q     = multiplier_in[br2m_pkg::WIDTH-1:0];
        stage_data[0].qprev = 1'b0;
        stage_data[0].m     = multiplicand_in[br2m_pkg::WIDTH-1:0];
    end

    assign stage_valid[0] = in_valid;
    assign in_stall       = !stage_ready[0];

    // one booth step per stage, WIDTH stages in a row
    for (genvar k = 0; k < br2m_pkg::WIDTH; k++)
    begin : g_step
        br2m_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[k]),
            .in_data   (stage_data[k]),
            .in_ready  (stage_ready[k]),
            .out_valid (stage_valid[k+1]),
            .out_data  (stage_data[k+1]),
            .out_ready (stage_ready[k+1])
        );
    end

    // last stage drains when the consumer is not stalling
    assign stage_ready[br2m_pkg::WIDTH] = !out_stall;
    assign out_valid = stage_valid[br2m_pkg::WIDTH];

    // product is accumulator over the multiplier register, sign-extended or truncated to the port width
    assign prod = $signed({stage_data[br2m_pkg::WIDTH].acc, stage_data[br2m_pkg::WIDTH].q});
    assign product_out = (br2m_pkg::PROD_W)'(prod);

    // input can only be held off when the pipe is full behind a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output side can drain");

    // a zero multiplicand never changes the accumulator, so the product is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stage_data[br2m_pkg::WIDTH].m == '0) |-> (product_out == '0))
    else $error("nonzero product from zero multiplicand");

    // a result held under stall keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(product_out)))
    else $error("stalled product changed or was dropped");

endmodule

// ----- bench/booth_radix2_signed_multiplier_top_tb.sv -----
// self-checking testbench for the radix-2 booth signed multiplier top level
module booth_radix2_signed_multiplier_top_tb;

    // sender and receiver idle budget before the run is declared hung
    localparam int IDLE_LIMIT = 2000;
    // random operand pairs after the directed table
    localparam int RANDOM_ITEMS = 830;
    // rows in the directed operand table
    localparam int DIRECTED_ROWS = 21;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [br2m_pkg::FIELD_W-1:0] multiplier_in = '0;
    logic signed [br2m_pkg::FIELD_W-1:0] multiplicand_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [br2m_pkg::PROD_W-1:0] product_out;

    // products still owed by the pipeline, oldest first
    logic signed [br2m_pkg::PROD_W-1:0] pending_products[$];
    int error_count = 0;
    int idle_cycles = 0;
    // when set, neither side inserts gaps or stalls
    bit quiet = 1'b0;

    booth_radix2_signed_multiplier_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .multiplier_in   (multiplier_in),
        .multiplicand_in (multiplicand_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .product_out     (product_out)
    );

    always #2 clk = ~clk;

    // exact signed product of the low WIDTH bits of each operand, sign-extended
    function automatic logic signed [br2m_pkg::PROD_W-1:0] signed_product(
        input logic [br2m_pkg::FIELD_W-1:0] mplier,
        input logic [br2m_pkg::FIELD_W-1:0] mcand
    );
        logic signed [br2m_pkg::WIDTH-1:0]   a;
        logic signed [br2m_pkg::WIDTH-1:0]   b;
        logic signed [2*br2m_pkg::WIDTH-1:0] p;
        a = mplier[br2m_pkg::WIDTH-1:0];
        b = mcand[br2m_pkg::WIDTH-1:0];
        p = a * b;
        return p;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 19);
        if (r < 11)
            return 0;
        else if (r < 18)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    // operand mix that leans on booth pair corners and the signed extremes
    function automatic logic [br2m_pkg::FIELD_W-1:0] random_operand();
        logic [br2m_pkg::FIELD_W-1:0] v;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = '0;
                    1: v = 32'h0000_0001;
                    2: v = '1;
                    3: v = 32'h8000_0000;
                    default: v = 32'h7fff_ffff;
                endcase
            end
            1: v = $urandom_range(0, 31) - 16;
            2: begin
                v = 32'h1 << $urandom_range(0, br2m_pkg::FIELD_W - 1);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            3: v = $urandom & $urandom & $urandom;
            4: v = $urandom | $urandom | $urandom;
            5: v = {$urandom_range(0, 1) ? 16'h5555 : 16'haaaa, 16'($urandom)};
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // present one operand pair, hold it until the pipeline takes it, then log the product
    task automatic send_operands(
        input logic [br2m_pkg::FIELD_W-1:0]       mplier,
        input logic [br2m_pkg::FIELD_W-1:0]       mcand,
        input logic signed [br2m_pkg::PROD_W-1:0] product,
        input int                                 gap
    );
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        multiplier_in   <= mplier;
        multiplicand_in <= mcand;
        // pre-edge in_stall decides acceptance at this edge
        do @(posedge clk); while (in_stall);
        pending_products.push_back(product);
    endtask

    // receiver: random stall bursts, free runs, and none at all while quiet
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (quiet)
            begin
                out_stall <= 1'b0;
                hold = 0;
            end
            else if (hold > 0)
                hold--;
            else if ($urandom_range(0, 1))
            begin
                out_stall <= 1'b0;
                hold = $urandom_range(0, 8);
            end
            else
            begin
                out_stall <= 1'b1;
                hold = idle_length();
            end
        end
    end

    // checker: every product transaction must match the oldest owed product
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_products.size() == 0)
            begin
                $error("product_out: unexpected transaction, actual %h", product_out);
                error_count++;
            end
            else
            begin
                if (product_out !== pending_products[0])
                begin
                    $error("product_out mismatch: expected %h, actual %h",
                           pending_products[0], product_out);
                    error_count++;
                end
                void'(pending_products.pop_front());
            end
        end
    end

    // watchdog: too long without a transaction on either side means a hang
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // directed operand table
    typedef struct {
        logic [br2m_pkg::FIELD_W-1:0]       mplier;
        logic [br2m_pkg::FIELD_W-1:0]       mcand;
        bit                                 known;
        logic signed [br2m_pkg::PROD_W-1:0] product;
    } operand_row_t;

    operand_row_t directed_rows [DIRECTED_ROWS] = '{
        // zero and unit products
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 64'h0000_0000_0000_0000},
        '{32'h0000_0001, 32'h0000_0001, 1'b1, 64'h0000_0000_0000_0001},
        '{32'hffff_ffff, 32'hffff_ffff, 1'b1, 64'h0000_0000_0000_0001},
        '{32'hffff_ffff, 32'h0000_0001, 1'b1, 64'hffff_ffff_ffff_ffff},
        // most negative operands need the extra accumulator bit
        '{32'h8000_0000, 32'h8000_0000, 1'b1, 64'h4000_0000_0000_0000},
        '{32'h8000_0000, 32'h7fff_ffff, 1'b1, 64'hc000_0000_8000_0000},
        '{32'h7fff_ffff, 32'h8000_0000, 1'b1, 64'hc000_0000_8000_0000},
        '{32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 64'h3fff_ffff_0000_0001},
        '{32'h8000_0000, 32'hffff_ffff, 1'b1, 64'h0000_0000_8000_0000},
        '{32'hffff_ffff, 32'h8000_0000, 1'b1, 64'h0000_0000_8000_0000},
        '{32'h8000_0000, 32'h0000_0000, 1'b1, 64'h0000_0000_0000_0000},
        '{32'h0000_0000, 32'h8000_0000, 1'b1, 64'h0000_0000_0000_0000},
        '{32'h7fff_ffff, 32'hffff_ffff, 1'b1, 64'hffff_ffff_8000_0001},
        '{32'h8000_0000, 32'h0000_0001, 1'b1, 64'hffff_ffff_8000_0000},
        '{32'h0000_0001, 32'h8000_0000, 1'b1, 64'hffff_ffff_8000_0000},
        '{32'h0000_0002, 32'h4000_0000, 1'b1, 64'h0000_0000_8000_0000},
        // alternating bits hit add and subtract pairs on nearly every step, then two mixed bit patterns
        '{32'h5555_5555, 32'haaaa_aaaa, 1'b0, '0},
        '{32'haaaa_aaaa, 32'h5555_5555, 1'b0, '0},
        '{32'haaaa_aaaa, 32'haaaa_aaaa, 1'b0, '0},
        '{32'h1234_5678, 32'h9abc_def0, 1'b0, '0},
        '{32'hffff_0000, 32'h0000_ffff, 1'b0, '0}
    };

    // stimulus and end of run
    initial
    begin
        logic [br2m_pkg::FIELD_W-1:0] a;
        logic [br2m_pkg::FIELD_W-1:0] b;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_operands(directed_rows[i].mplier, directed_rows[i].mcand,
                          directed_rows[i].known ? directed_rows[i].product
                                                 : signed_product(directed_rows[i].mplier,
                                                                  directed_rows[i].mcand),
                          idle_length());

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // back-to-back stretches with no idling on either side
            quiet = (n >= 100 && n < 200) || (n >= 600 && n < 700);
            // drain the pipeline completely once mid-run
            if (n == 400)
            begin
                in_valid <= 1'b0;
                do @(posedge clk); while (pending_products.size() != 0);
            end
            a = random_operand();
            b = random_operand();
            send_operands(a, b, signed_product(a, b), quiet ? 0 : idle_length());
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        // wait for the last products, then keep watching for stray transactions
        while (pending_products.size() != 0) @(posedge clk);
        repeat (br2m_pkg::WIDTH + 8) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
